>>> sv/indexed_ordered_list_engine_macros.svh
// ----------------------------------------------------------------------------
// indexed ordered list engine assertion macros
// shared concurrent assertion shorthands for the list engine
// ----------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_LIST_ENGINE_MACROS_SVH
`define INDEXED_ORDERED_LIST_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define IOLE_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define IOLE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/iole_pkg.sv
// ----------------------------------------------------------------------------
// iole_pkg
// shared types and constants of the indexed ordered list engine
// ----------------------------------------------------------------------------
package iole_pkg;

    localparam int DEPTH_DEFAULT         = 16;
    localparam int ELEMENT_WIDTH_DEFAULT = 32;

    // fixed field widths of the transaction ports
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 4;
    localparam int LEN_W    = 5;

    // match bits examined per cycle by the search scanner
    localparam int SCAN_CHUNK = 8;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_GET    = 3'd2,
        OP_SET    = 3'd3,
        OP_REMOVE = 3'd4,
        OP_FIND   = 3'd5,
        OP_CLEAR  = 3'd6
    } iole_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_MISS  = 2'd3
    } iole_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } iole_state_t;

    // per-cell update command
    typedef struct packed {
        logic load;
        logic shift_up;
        logic shift_down;
    } iole_cell_ctrl_t;

    // search scanner report
    typedef struct packed {
        logic               done;
        logic               hit;
        logic [FOUND_W-1:0] index;
    } iole_scan_res_t;

endpackage

>>> sv/iole_cell.sv
// ----------------------------------------------------------------------------
// iole_cell
// one list slot: holds an element, shifts with its neighbors, compares
// ----------------------------------------------------------------------------
module iole_cell #(
    parameter int ELEMENT_WIDTH = iole_pkg::ELEMENT_WIDTH_DEFAULT
) (
    input  logic                        aclk,
    input  iole_pkg::iole_cell_ctrl_t   ctrl,
    input  logic [ELEMENT_WIDTH-1:0]    load_data,
    input  logic [ELEMENT_WIDTH-1:0]    prev_data,
    input  logic [ELEMENT_WIDTH-1:0]    next_data,
    input  logic [ELEMENT_WIDTH-1:0]    cmp_data,
    output logic [ELEMENT_WIDTH-1:0]    entry,
    output logic                        match
);

    logic [ELEMENT_WIDTH-1:0] entry_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            entry_reg <= load_data;
        end else if (ctrl.shift_up) begin
            entry_reg <= prev_data;
        end else if (ctrl.shift_down) begin
            entry_reg <= next_data;
        end
    end

    assign entry = entry_reg;
    assign match = (entry_reg == cmp_data);

endmodule

>>> sv/iole_scan.sv
// ----------------------------------------------------------------------------
// iole_scan
// first-match search over the cell match bits, one chunk per cycle
// ----------------------------------------------------------------------------
module iole_scan #(
    parameter int DEPTH = iole_pkg::DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [DEPTH-1:0]                match_vec,
    input  logic [$clog2(DEPTH+1)-1:0]      count,
    output iole_pkg::iole_scan_res_t        res
);

    localparam int CHUNK  = iole_pkg::SCAN_CHUNK;
    localparam int SCAN_W = ((DEPTH + CHUNK - 1) / CHUNK) * CHUNK;
    localparam int SB_W   = $clog2(SCAN_W + CHUNK + 1);
    localparam int ENC_W  = $clog2(CHUNK);

    logic [SCAN_W-1:0] vec_reg;
    logic [SB_W-1:0]   base_reg;
    logic              busy_reg;

    logic [CHUNK-1:0]  chunk;
    logic [ENC_W-1:0]  enc;
    logic              any_hit;
    logic              last_chunk;
    logic [SB_W-1:0]   hit_idx;

    assign chunk = vec_reg[CHUNK-1:0];

    // lowest set bit of the current chunk
    always_comb begin
        enc = '0;
        for (int k = CHUNK - 1; k >= 0; k--) begin
            if (chunk[k]) begin
                enc = ENC_W'(k);
            end
        end
    end

    assign any_hit    = |chunk;
    assign last_chunk = (base_reg + SB_W'(CHUNK)) >= SB_W'(count);
    assign hit_idx    = base_reg + SB_W'(enc);

    assign res.done  = busy_reg && (any_hit || last_chunk);
    assign res.hit   = any_hit;
    assign res.index = hit_idx[iole_pkg::FOUND_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (res.done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            vec_reg  <= SCAN_W'(match_vec);
            base_reg <= '0;
        end else if (busy_reg) begin
            vec_reg  <= vec_reg >> CHUNK;
            base_reg <= base_reg + SB_W'(CHUNK);
        end
    end

endmodule

>>> sv/indexed_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list_engine
// ordered list of element words with indexed insert, remove and search
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one request per transaction: s_operation selects
//   append, insert, get, set, remove, find or clear; s_position is the
//   target index and s_element_value the word to store or search for
//   m_ channel returns one result per request: status, read or removed
//   word, found index, list length after the request and an empty flag
//   flow: the accept edge latches the request, the execute state lets the
//   affected cells shift or load in parallel, then the result is loaded
//   into the output register and m_valid rises, for all but find; a new
//   request is taken only once the previous result is in that register
//   a find adds a scan by the chunked first-match scanner over 8-bit
//   chunks, stopping at the first match or at the end of the length
//   a stalled receiver holds the result in the output register; the next
//   request is taken in the cycle that result is consumed
//   reset clears the length and the handshake state; the cell contents
//   are not reset and are only read below the length
// ----------------------------------------------------------------------------
`include "indexed_ordered_list_engine_macros.svh"

module indexed_ordered_list_engine #(
    parameter int DEPTH         = iole_pkg::DEPTH_DEFAULT,
    parameter int ELEMENT_WIDTH = iole_pkg::ELEMENT_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [iole_pkg::OP_W-1:0]         s_operation,
    input  logic [iole_pkg::POS_W-1:0]        s_position,
    input  logic [iole_pkg::VALUE_W-1:0]      s_element_value,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [iole_pkg::STATUS_W-1:0]     m_status,
    output logic [iole_pkg::VALUE_W-1:0]      m_read_value,
    output logic [iole_pkg::FOUND_W-1:0]      m_found_index,
    output logic [iole_pkg::LEN_W-1:0]        m_list_length,
    output logic                              m_is_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    // compare width wide enough for both the position field and the length
    localparam int PW    = (CNT_W > iole_pkg::POS_W) ? CNT_W : iole_pkg::POS_W;

    // control state
    iole_pkg::iole_state_t  state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   m_valid_reg;

    // latched request
    iole_pkg::iole_op_t             op_reg;
    logic [iole_pkg::POS_W-1:0]     pos_reg;
    logic [ELEMENT_WIDTH-1:0]       val_reg;

    // result register
    iole_pkg::iole_status_t         status_reg;
    logic [iole_pkg::VALUE_W-1:0]   read_reg;
    logic [iole_pkg::FOUND_W-1:0]   found_reg;
    logic [iole_pkg::LEN_W-1:0]     len_reg;
    logic                           empty_reg;

    // result being loaded
    logic                           out_load;
    iole_pkg::iole_status_t         out_status;
    logic [iole_pkg::VALUE_W-1:0]   out_read;
    logic [iole_pkg::FOUND_W-1:0]   out_found;

    // execute-cycle decode
    logic                           exec;
    logic [PW-1:0]                  pos_w;
    logic [PW-1:0]                  cnt_w;
    logic                           list_full;
    logic                           do_append, do_insert, do_set, do_remove;
    iole_pkg::iole_status_t         exec_status;
    logic [iole_pkg::VALUE_W-1:0]   exec_read;

    // cell chain
    logic [ELEMENT_WIDTH-1:0]       cell_q    [DEPTH];
    logic [ELEMENT_WIDTH-1:0]       cell_prev [DEPTH];
    logic [ELEMENT_WIDTH-1:0]       cell_next [DEPTH];
    iole_pkg::iole_cell_ctrl_t      cell_ctrl [DEPTH];
    logic [DEPTH-1:0]               cell_match;
    logic [DEPTH-1:0]               match_vec;

    iole_pkg::iole_scan_res_t       scan_res;
    logic                           scan_start;

    // take a request only when idle and the result slot is free or draining
    assign s_ready = (state_reg == iole_pkg::ST_IDLE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= iole_pkg::iole_op_t'(s_operation);
            pos_reg <= s_position;
            val_reg <= ELEMENT_WIDTH'(s_element_value);
        end
    end

    assign exec      = (state_reg == iole_pkg::ST_EXEC);
    assign pos_w     = PW'(pos_reg);
    assign cnt_w     = PW'(count_reg);
    assign list_full = (count_reg == CNT_W'(DEPTH));

    // request decode and length update, only active in the execute cycle
    always_comb begin
        do_append   = 1'b0;
        do_insert   = 1'b0;
        do_set      = 1'b0;
        do_remove   = 1'b0;
        exec_status = iole_pkg::STAT_OK;
        exec_read   = '0;
        count_next  = count_reg;
        if (exec) begin
            case (op_reg)
                iole_pkg::OP_APPEND: begin
                    if (list_full) begin
                        exec_status = iole_pkg::STAT_FULL;
                    end else begin
                        do_append  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                iole_pkg::OP_INSERT: begin
                    if (pos_w > cnt_w) begin
                        exec_status = iole_pkg::STAT_RANGE;
                    end else if (list_full) begin
                        exec_status = iole_pkg::STAT_FULL;
                    end else begin
                        do_insert  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                iole_pkg::OP_GET: begin
                    if (pos_w >= cnt_w) begin
                        exec_status = iole_pkg::STAT_RANGE;
                    end else begin
                        exec_read = iole_pkg::VALUE_W'(cell_q[pos_w[IDX_W-1:0]]);
                    end
                end
                iole_pkg::OP_SET: begin
                    if (pos_w >= cnt_w) begin
                        exec_status = iole_pkg::STAT_RANGE;
                    end else begin
                        do_set = 1'b1;
                    end
                end
                iole_pkg::OP_REMOVE: begin
                    if (pos_w >= cnt_w) begin
                        exec_status = iole_pkg::STAT_RANGE;
                    end else begin
                        exec_read  = iole_pkg::VALUE_W'(cell_q[pos_w[IDX_W-1:0]]);
                        do_remove  = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                iole_pkg::OP_FIND: begin
                    // result comes from the scanner
                end
                iole_pkg::OP_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    // unused code: no change, plain ok result
                end
            endcase
        end
    end

    // cell chain: each cell knows its own index and decodes its command
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [PW-1:0] IDX  = PW'(i);
        localparam logic [PW-1:0] IDX1 = PW'(i + 1);

        if (i == 0) begin : g_first
            assign cell_prev[i] = '0;
        end else begin : g_mid_lo
            assign cell_prev[i] = cell_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign cell_next[i] = '0;
        end else begin : g_mid_hi
            assign cell_next[i] = cell_q[i+1];
        end

        // append writes the slot at the length, insert and set the target slot
        assign cell_ctrl[i].load = (do_append && (cnt_w == IDX))
                                || ((do_insert || do_set) && (pos_w == IDX));
        // insert opens a gap: slots above the target up to the old length move up
        assign cell_ctrl[i].shift_up   = do_insert && (IDX > pos_w) && (IDX <= cnt_w);
        // remove closes the gap: slots from the target take their upper neighbor
        assign cell_ctrl[i].shift_down = do_remove && (IDX >= pos_w) && (IDX1 < cnt_w);

        iole_cell #(
            .ELEMENT_WIDTH (ELEMENT_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[i]),
            .load_data (val_reg),
            .prev_data (cell_prev[i]),
            .next_data (cell_next[i]),
            .cmp_data  (val_reg),
            .entry     (cell_q[i]),
            .match     (cell_match[i])
        );

        // only stored slots can match
        assign match_vec[i] = cell_match[i] && (IDX < cnt_w);
    end

    assign scan_start = exec && (op_reg == iole_pkg::OP_FIND);

    iole_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (scan_start),
        .match_vec (match_vec),
        .count     (count_reg),
        .res       (scan_res)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= iole_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        out_status = iole_pkg::STAT_OK;
        out_read   = '0;
        out_found  = '0;
        case (state_reg)
            iole_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = iole_pkg::ST_EXEC;
                end
            end
            iole_pkg::ST_EXEC: begin
                if (op_reg == iole_pkg::OP_FIND) begin
                    state_next = iole_pkg::ST_SCAN;
                end else begin
                    state_next = iole_pkg::ST_IDLE;
                    out_load   = 1'b1;
                    out_status = exec_status;
                    out_read   = exec_read;
                end
            end
            iole_pkg::ST_SCAN: begin
                if (scan_res.done) begin
                    state_next = iole_pkg::ST_IDLE;
                    out_load   = 1'b1;
                    out_status = scan_res.hit ? iole_pkg::STAT_OK : iole_pkg::STAT_MISS;
                    out_found  = scan_res.hit ? scan_res.index : '0;
                end
            end
            default: begin
                state_next = iole_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            status_reg <= out_status;
            read_reg   <= out_read;
            found_reg  <= out_found;
            len_reg    <= iole_pkg::LEN_W'(count_next);
            empty_reg  <= (count_next == '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_read_value  = read_reg;
    assign m_found_index = found_reg;
    assign m_list_length = len_reg;
    assign m_is_empty    = empty_reg;

    // checks
    `IOLE_ASSERT_IMPLIES(a_len_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH), "length above depth")

    `IOLE_ASSERT_NEXT(a_exec_result, aclk, aresetn, exec && (op_reg != iole_pkg::OP_FIND), m_valid_reg, "no result after execute")

    `IOLE_ASSERT_NEXT(a_remove_len, aclk, aresetn, do_remove, count_reg == $past(count_reg) - 1'b1, "remove did not shrink list")

    `IOLE_ASSERT_IMPLIES(a_empty_flag, aclk, aresetn, m_valid_reg, empty_reg == (len_reg == '0), "empty flag disagrees with length")

endmodule
